FILE: src/icaf_pkg.sv
// Shared constants, register indexes and helper functions for the attitude filter.
// No dependencies; imported by icaf_cordic and the top level.
package icaf_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_GYRO_X = 3'd0;
    localparam logic [2:0] CFG_GYRO_Y = 3'd1;
    localparam logic [2:0] CFG_GYRO_Z = 3'd2;
    localparam logic [2:0] CFG_WEIGHT = 3'd3;
    localparam logic [2:0] CFG_PERIOD = 3'd4;

    localparam logic [15:0] WEIGHT_RESET = 16'd62259;
    localparam logic [23:0] PERIOD_RESET = 24'd83886;

    // Rate scaling: round(x / (16*131*256)), done as a 4096 shift then divide by 131.
    // The divide multiplies by ceil(2^31/131) and keeps bits 47:31; exact below 2^24.
    localparam logic [44:0] RATE_ROUND = 45'd268288;
    localparam logic [8:0]  RATE_DIV   = 9'd131;
    localparam logic [23:0] RATE_RECIP = 24'd16393005;
    localparam int          SQRT_BITS  = 24;

    // 90 degrees in Q16.16
    localparam logic signed [25:0] DEG90 = 26'sd5898240;

    // atan(2^-i) in Q16.16 degrees
    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        begin
            case (idx)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

    // Clamp to the signed Q16.16 range
    function automatic logic signed [31:0] sat_q16(input logic signed [35:0] v);
        logic signed [31:0] r;
        begin
            if (v > 36'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -36'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

FILE: src/icaf_cordic.sv
// Vectoring CORDIC that returns atan2(y, x) in Q16.16 degrees, one micro-rotation a cycle.
// Depends on icaf_pkg for the angle table and the 90 degree constant.
module icaf_cordic
    import icaf_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [24:0]  y_in,
    input  logic signed [24:0]  x_in,
    output logic                done,
    output logic signed [25:0]  z_out
);

    localparam int CW = $clog2(STEPS);

    typedef enum logic { C_IDLE, C_RUN } cstate_t;

    cstate_t                state_reg;
    logic signed [27:0]     x_reg;
    logic signed [27:0]     y_reg;
    logic signed [25:0]     z_reg;
    logic [CW-1:0]          ctr_reg;
    logic                   done_reg;

    logic signed [27:0]     xi;
    logic signed [27:0]     yi;
    logic signed [27:0]     dx;
    logic signed [27:0]     dy;
    logic signed [25:0]     at;

    assign xi = 28'(x_in);
    assign yi = 28'(y_in);
    assign dx = y_reg >>> ctr_reg;
    assign dy = x_reg >>> ctr_reg;
    assign at = $signed({4'b0, atan_entry(5'(ctr_reg))});

    // Load, pre-rotate into the right half plane, then iterate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            ctr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        ctr_reg <= '0;
                        if (x_in == 25'sd0 && y_in == 25'sd0)
                        begin
                            z_reg    <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= C_RUN;
                            if (x_in < 0)
                            begin
                                if (y_in >= 0)
                                begin
                                    x_reg <= yi;
                                    y_reg <= -xi;
                                    z_reg <= DEG90;
                                end
                                else
                                begin
                                    x_reg <= -yi;
                                    y_reg <= xi;
                                    z_reg <= -DEG90;
                                end
                            end
                            else
                            begin
                                x_reg <= xi;
                                y_reg <= yi;
                                z_reg <= '0;
                            end
                        end
                    end
                end
                C_RUN:
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + at;
                    end
                    else
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - at;
                    end
                    if (ctr_reg == CW'(STEPS - 1))
                    begin
                        state_reg <= C_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        ctr_reg <= ctr_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign z_out = z_reg;

endmodule

FILE: src/imu_complementary_attitude_filter.sv
// Each sample passes through three rate scalings, a 24-step square root and two CORDIC
// runs before its result is registered; a CORDIC run on a zero vector skips the
// micro-rotations. One sample is taken at a time: s_tready is high only in S_IDLE.
// Reset (rst_n, asynchronous, active low) clears the angles to zero, the offsets to zero,
// the weight to 0.95 and the period to 0.005 s.
module imu_complementary_attitude_filter
    import icaf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each)
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // roll_deg, pitch_deg, yaw_deg (32 bits each)
    output logic [95:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_RMUL, S_RNORM, S_RDIV, S_RSTORE, S_CRS, S_CRW, S_SQY, S_SQZ,
        S_SQRT, S_CPS, S_CPW, S_BMUL1, S_BMUL2, S_BSAT, S_DONE
    } state_t;

    state_t                 state_reg;
    logic signed [19:0]     gyro_off_reg [3];
    logic [15:0]            weight_reg;
    logic [23:0]            period_reg;
    logic signed [15:0]     ax_reg;
    logic signed [15:0]     ay_reg;
    logic signed [15:0]     az_reg;
    logic signed [15:0]     rate_reg [3];
    logic signed [26:0]     inc_reg [3];
    logic [1:0]             k_reg;
    logic [4:0]             cnt_reg;
    logic [7:0]             div_rem_reg;
    logic [25:0]            div_q_reg;
    logic [32:0]            div_n_reg;
    logic                   sign_reg;
    logic [47:0]            op_reg;
    logic [26:0]            srem_reg;
    logic [23:0]            root_reg;
    logic signed [25:0]     roll_acc_reg;
    logic signed [25:0]     pitch_acc_reg;
    logic signed [51:0]     acc_reg;
    logic                   bsel_reg;
    logic signed [31:0]     roll_reg;
    logic signed [31:0]     pitch_reg;
    logic signed [31:0]     yaw_reg;
    logic                   m_tvalid_reg;
    logic [95:0]            m_tdata_reg;

    logic signed [25:0]     mul_a;
    logic signed [33:0]     mul_b;
    logic signed [59:0]     mul_p;
    logic signed [20:0]     diff;
    logic [45:0]            mag;
    logic [44:0]            mag_rnd;
    logic [23:0]            div_num;
    logic [16:0]            div_qt;
    logic [7:0]             div_r;
    logic [26:0]            rs;
    logic [26:0]            trial;
    logic                   sq_ge;
    logic signed [32:0]     gsum;
    logic signed [25:0]     acc_sel;
    logic signed [35:0]     blend_sh;
    logic signed [35:0]     yaw_sum;
    logic                   cd_start;
    logic signed [24:0]     cd_y;
    logic signed [24:0]     cd_x;
    logic                   cd_done;
    logic signed [25:0]     cd_z;
    logic signed [16:0]     ax_neg;

    // Gyro bias removal, scaled to raw counts with four fractional bits
    assign diff = $signed({rate_reg[k_reg][15], rate_reg[k_reg], 4'b0})
                - 21'(gyro_off_reg[k_reg]);

    // Gyro-propagated angle and accelerometer angle for the axis being blended
    assign gsum    = bsel_reg ? (33'(pitch_reg) + 33'(inc_reg[1]))
                              : (33'(roll_reg) + 33'(inc_reg[0]));
    assign acc_sel = bsel_reg ? pitch_acc_reg : roll_acc_reg;

    // Divide by 131 in two halves: upper 17 bits first, then remainder with lower 16 bits
    assign div_num = (cnt_reg == 5'd0) ? 24'(div_n_reg[32:16])
                                       : {div_rem_reg, div_n_reg[15:0]};

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RMUL:
            begin
                mul_a = 26'(diff);
                mul_b = $signed({10'b0, period_reg});
            end
            S_RDIV:
            begin
                mul_a = $signed({2'b0, RATE_RECIP});
                mul_b = $signed({10'b0, div_num});
            end
            S_SQY:
            begin
                mul_a = 26'(ay_reg);
                mul_b = 34'(ay_reg);
            end
            S_SQZ:
            begin
                mul_a = 26'(az_reg);
                mul_b = 34'(az_reg);
            end
            S_BMUL1:
            begin
                mul_a = $signed({10'b0, weight_reg});
                mul_b = 34'(gsum);
            end
            S_BMUL2:
            begin
                mul_a = $signed(26'(17'h10000 - {1'b0, weight_reg}));
                mul_b = 34'(acc_sel);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Rounded magnitude for the divide by 131
    assign mag     = acc_reg[51] ? 46'(-acc_reg) : 46'(acc_reg);
    assign mag_rnd = 45'(mag) + RATE_ROUND;

    // Reciprocal quotient and remainder of the upper half
    assign div_qt = mul_p[47:31];
    assign div_r  = 8'(div_n_reg[32:16] - 17'(div_q_reg[25:16]) * 17'(RATE_DIV));

    // Square root step, two radicand bits a cycle
    assign rs    = {srem_reg[24:0], op_reg[47:46]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign sq_ge = (rs >= trial);

    assign blend_sh = 36'(acc_reg >>> 16);
    assign yaw_sum  = 36'(yaw_reg) + 36'(inc_reg[2]);

    // CORDIC operands: roll from (ay, az), pitch from (-ax, magnitude)
    assign ax_neg   = -$signed({ax_reg[15], ax_reg});
    assign cd_start = (state_reg == S_CRS) || (state_reg == S_CPS);
    assign cd_y     = (state_reg == S_CPS) ? $signed({ax_neg, 8'b0})
                                           : $signed({ay_reg[15], ay_reg, 8'b0});
    assign cd_x     = (state_reg == S_CPS) ? $signed({1'b0, root_reg})
                                           : $signed({az_reg[15], az_reg, 8'b0});

    icaf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .y_in  (cd_y),
        .x_in  (cd_x),
        .done  (cd_done),
        .z_out (cd_z)
    );

    // Sequencer, configuration registers, filter state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            gyro_off_reg[0] <= '0;
            gyro_off_reg[1] <= '0;
            gyro_off_reg[2] <= '0;
            weight_reg      <= WEIGHT_RESET;
            period_reg      <= PERIOD_RESET;
            roll_reg        <= '0;
            pitch_reg       <= '0;
            yaw_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            k_reg           <= '0;
            cnt_reg         <= '0;
            bsel_reg        <= 1'b0;
        end
        else
        begin
            // Configuration writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GYRO_X: gyro_off_reg[0] <= cfg_data[19:0];
                    CFG_GYRO_Y: gyro_off_reg[1] <= cfg_data[19:0];
                    CFG_GYRO_Z: gyro_off_reg[2] <= cfg_data[19:0];
                    CFG_WEIGHT: weight_reg      <= cfg_data[15:0];
                    CFG_PERIOD: period_reg      <= cfg_data;
                    default:    ;
                endcase
            end

            // Drop the output once taken, unless a new result replaces it
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        ax_reg      <= s_tdata[15:0];
                        ay_reg      <= s_tdata[31:16];
                        az_reg      <= s_tdata[47:32];
                        rate_reg[0] <= s_tdata[63:48];
                        rate_reg[1] <= s_tdata[79:64];
                        rate_reg[2] <= s_tdata[95:80];
                        k_reg       <= '0;
                        state_reg   <= S_RMUL;
                    end
                end
                S_RMUL:
                begin
                    acc_reg   <= 52'(mul_p);
                    state_reg <= S_RNORM;
                end
                S_RNORM:
                begin
                    sign_reg  <= acc_reg[51];
                    div_n_reg <= mag_rnd[44:12];
                    cnt_reg   <= '0;
                    state_reg <= S_RDIV;
                end
                S_RDIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    case (cnt_reg)
                        5'd0:
                        begin
                            div_q_reg <= {div_qt[9:0], 16'b0};
                        end
                        5'd1:
                        begin
                            div_rem_reg <= div_r;
                        end
                        default:
                        begin
                            div_q_reg <= {div_q_reg[25:16], div_qt[15:0]};
                            state_reg <= S_RSTORE;
                        end
                    endcase
                end
                S_RSTORE:
                begin
                    inc_reg[k_reg] <= sign_reg ? -$signed({1'b0, div_q_reg})
                                               : $signed({1'b0, div_q_reg});
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= S_CRS;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_RMUL;
                    end
                end
                S_CRS:
                begin
                    state_reg <= S_CRW;
                end
                S_CRW:
                begin
                    if (cd_done)
                    begin
                        roll_acc_reg <= cd_z;
                        state_reg    <= S_SQY;
                    end
                end
                S_SQY:
                begin
                    acc_reg   <= 52'(mul_p);
                    state_reg <= S_SQZ;
                end
                S_SQZ:
                begin
                    op_reg    <= {32'(acc_reg + 52'(mul_p)), 16'b0};
                    srem_reg  <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    srem_reg <= sq_ge ? (rs - trial) : rs;
                    root_reg <= {root_reg[SQRT_BITS-2:0], sq_ge};
                    op_reg   <= {op_reg[45:0], 2'b0};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(SQRT_BITS - 1))
                        state_reg <= S_CPS;
                end
                S_CPS:
                begin
                    state_reg <= S_CPW;
                end
                S_CPW:
                begin
                    if (cd_done)
                    begin
                        pitch_acc_reg <= cd_z;
                        bsel_reg      <= 1'b0;
                        state_reg     <= S_BMUL1;
                    end
                end
                S_BMUL1:
                begin
                    acc_reg   <= 52'(mul_p) + 52'sd32768;
                    state_reg <= S_BMUL2;
                end
                S_BMUL2:
                begin
                    acc_reg   <= acc_reg + 52'(mul_p);
                    state_reg <= S_BSAT;
                end
                S_BSAT:
                begin
                    if (bsel_reg)
                    begin
                        pitch_reg <= sat_q16(blend_sh);
                        yaw_reg   <= sat_q16(yaw_sum);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        roll_reg  <= sat_q16(blend_sh);
                        bsel_reg  <= 1'b1;
                        state_reg <= S_BMUL1;
                    end
                end
                S_DONE:
                begin
                    // Hold until the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {yaw_reg, pitch_reg, roll_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule
